[rtl/core/lpht_pkg.sv]
// Shared constants and types of the linear-probing hash table.
// Used by lpht_mix and linear_probe_hash_table; depends on nothing.
package lpht_pkg;

  localparam int unsigned DEF_TABLE_SLOTS = 1024;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned S_DATA_W = 136;  // 130 bits of fields, padded to bytes
  localparam int unsigned M_DATA_W = 72;   // 66 bits of fields, padded to bytes
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned PDATA_W = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [CNT_W-1:0] THRESH_RESET   = CNT_W'(768);
  localparam logic [VAL_W-1:0] TOMB_RESET     = VAL_W'(1);

  // Register select: paddr bit 3 picks the register (byte address 8*i).
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_TOMB   = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_UPSERT = 2'd3
  } action_t;

  // Finalizer constants of the key mix.
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
  localparam int unsigned MIX_S0 = 30;
  localparam int unsigned MIX_S1 = 27;
  localparam int unsigned MIX_S2 = 31;

endpackage

[rtl/core/lpht_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module lpht_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/lpht_mix.sv]
// Iterative 64-bit key mix: xor-shift, multiply, xor-shift, multiply, xor-shift.
// Each 64x64 (low half) multiply runs as three 32x32 partial products on one
// shared multiplier. Depends on lpht_pkg.
module lpht_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  import lpht_pkg::*;

  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  phase;
  logic        second;
  logic        running;

  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] hi_sum;
  logic [63:0] y;

  always_comb begin
    mul_const = second ? MIX_C2 : MIX_C1;
    mul_a     = (phase == 2'd1) ? x[63:32] : x[31:0];
    mul_b     = (phase == 2'd2) ? mul_const[63:32] : mul_const[31:0];
    hi_sum    = acc[63:32] + prod[31:0];
    y         = {hi_sum, acc[31:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      phase   <= 2'd0;
      second  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        phase   <= 2'd0;
        second  <= 1'b0;
        x       <= key ^ (key >> MIX_S0);
      end else if (running) begin
        prod  <= 64'(mul_a) * 64'(mul_b);
        phase <= phase + 2'd1;
        case (phase)
          2'd1:    acc <= prod;
          2'd2:    acc <= y;
          default: acc <= acc;
        endcase
        // Last phase: close the product and apply the xor-shift.
        if (phase == 2'd3) begin
          if (second) begin
            x       <= y ^ (y >> MIX_S2);
            running <= 1'b0;
            done    <= 1'b1;
          end else begin
            x      <= y ^ (y >> MIX_S1);
            second <= 1'b1;
          end
        end
      end
    end
  end

  assign hash = x;

endmodule

[rtl/core/linear_probe_hash_table.sv]
// Linear-probing key/value table: top level with sequencer, config registers
// and slot memories. Depends on lpht_pkg, lpht_mix and lpht_ram.
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------
//   s_*      | in        | action, key, value_in
//   m_*      | out       | ok, value_out, over_threshold
//   APB      | in/out    | grow_threshold (0x0), tombstone_code (0x8)
//
// An item is accepted, runs the key mix on its shared multiplier, then visits
// slots (memory read, then check) and loads the result. A refused item (zero
// key, or the tombstone value on an insert or upsert) skips the mix and the
// probe. The next item is taken once the result is loaded into the output
// register, even while it waits.
// After reset the key memory is swept to empty, one slot a cycle, through all
// TABLE_SLOTS slots; s_tready stays low meanwhile. TABLE_SLOTS must be a
// power of two.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] action, [65:2] key, [129:66] value_in, zero above
  input  logic [lpht_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] ok, [64:1] value_out, [65] over_threshold, zero above
  output logic [lpht_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpht_pkg::ADDR_W-1:0]    paddr,
  input  logic [lpht_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpht_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_RESULT
  } state_t;

  state_t            state;
  action_t           act;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  probes;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  grow_threshold;
  logic [VAL_W-1:0]  tombstone_code;
  logic              res_ok;
  logic [VAL_W-1:0]  res_val;

  logic              cfg_wr;
  logic              in_acc;
  action_t           in_act;
  logic [KEY_W-1:0]  in_key;
  logic [VAL_W-1:0]  in_val;
  logic              in_reject;
  logic              mix_done;
  logic [63:0]       mix_hash;

  logic              key_we;
  logic [KEY_W-1:0]  key_wdata;
  logic [KEY_W-1:0]  key_rdata;
  logic              val_we;
  logic [VAL_W-1:0]  val_rdata;
  logic              hit;
  logic              empty;
  logic              is_insert;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[3])
      REG_THRESH: prdata = PDATA_W'(grow_threshold);
      REG_TOMB:   prdata = tombstone_code;
      default:    prdata = '0;
    endcase
  end

  // Input item decode.
  assign in_act    = action_t'(s_tdata[1:0]);
  assign in_key    = s_tdata[65:2];
  assign in_val    = s_tdata[129:66];
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid & s_tready;
  assign in_reject = (in_key == '0) ||
                     (((in_act == ACT_INSERT) || (in_act == ACT_UPSERT)) &&
                      (in_val == tombstone_code));

  lpht_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc & ~in_reject),
    .key   (in_key),
    .done  (mix_done),
    .hash  (mix_hash)
  );

  // Probe check on the slot read last cycle.
  assign hit       = (key_rdata == key_q);
  assign empty     = (key_rdata == '0);
  assign is_insert = (act == ACT_INSERT) || (act == ACT_UPSERT);

  always_comb begin
    key_we    = 1'b0;
    key_wdata = key_q;
    val_we    = 1'b0;
    if (state == ST_CLEAR) begin
      key_we    = 1'b1;
      key_wdata = '0;
    end else if (state == ST_PROBE_CHK) begin
      if (hit) begin
        val_we = (act == ACT_UPDATE) || (act == ACT_UPSERT);
      end else if (empty && is_insert) begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
    end
  end

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .addr  (slot),
    .wdata (key_wdata),
    .rdata (key_rdata)
  );

  lpht_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SLOTS)
  ) u_vals (
    .clk   (clk),
    .we    (val_we),
    .addr  (slot),
    .wdata (val_q),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      slot           <= '0;
      probes         <= '0;
      entry_count    <= '0;
      grow_threshold <= THRESH_RESET;
      tombstone_code <= TOMB_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[3] == REG_TOMB) begin
          tombstone_code <= pwdata;
        end else begin
          grow_threshold <= pwdata[CNT_W-1:0];
        end
      end

      // Drop the item once taken; the result state reloads it itself.
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == IDX_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            act     <= in_act;
            key_q   <= in_key;
            val_q   <= in_val;
            res_ok  <= 1'b0;
            res_val <= '0;
            probes  <= '0;
            state   <= in_reject ? ST_RESULT : ST_HASH;
          end
        end
        ST_HASH: begin
          if (mix_done) begin
            slot  <= mix_hash[IDX_W-1:0];
            state <= ST_PROBE_RD;
          end
        end
        ST_PROBE_RD: begin
          state <= ST_PROBE_CHK;
        end
        ST_PROBE_CHK: begin
          if (hit) begin
            res_ok <= (act != ACT_INSERT);
            if (act == ACT_FIND) begin
              res_val <= val_rdata;
            end
            state <= ST_RESULT;
          end else if (empty) begin
            if (is_insert) begin
              res_ok <= 1'b1;
              if (entry_count != COUNT_MAX) begin
                entry_count <= entry_count + 1'b1;
              end
            end
            state <= ST_RESULT;
          end else if (probes == IDX_LAST) begin
            // Every slot visited: table full or key absent.
            state <= ST_RESULT;
          end else begin
            slot   <= slot + 1'b1;
            probes <= probes + 1'b1;
            state  <= ST_PROBE_RD;
          end
        end
        ST_RESULT: begin
          // Hold until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, (entry_count >= grow_threshold), res_val, res_ok};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
